>>> sv/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg: shared types and constants of the nearest palette colour search
// Field widths, the controller state type and the command word that the
// controller sends to the datapath.
// ----------------------------------------------------------------------------
package npcs_pkg;

  // Field widths fixed by the stream format.
  localparam int COMP_W = 8;
  localparam int IDX_W  = 4;
  localparam int DIST_W = 18;
  localparam int CFG_W  = 5;

  // Register reset value and the distance reported when nothing is searched.
  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;

  // Operation carried in tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN_A,
    ST_DRAIN_B,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // latch the query pixel and reset the best match
    logic wr_en;     // write the incoming word into the palette
    logic rd_en;     // read one palette entry at the scan address
    logic load_out;  // copy the best match into the output register
  } cmd_t;

endpackage

>>> sv/nearest_palette_color_search.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search: nearest palette colour by squared RGB distance
// Top level joining the controller and the datapath to the stream ports.
// ----------------------------------------------------------------------------
// A word with tuser low writes its colour into palette slot entry_index, and
// the next word can follow straight after. A word with tuser high is a query:
// the block reads min(entries_in_use, PALETTE_DEPTH) = N entries one per
// cycle through the single read port of the palette memory, then drains the
// distance and compare pipeline and loads the output register before the
// input reopens (with N zero it goes straight to the load). The result word
// waits in its own register, so the next word is taken while it is still
// unread; only a query that finishes while the previous result is still held
// waits for it to be taken. Slots are undefined after reset and must be
// written before a query searches them.
// The entry count register may be written at any time the block is idle.
module nearest_palette_color_search import npcs_pkg::*; #(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index[3:0], red[11:4], green[19:12],
                                  // blue[27:20], zero[31:28]
  input  logic        in_tuser,   // opcode[0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // nearest_index[3:0], nearest_distance_sq[21:4],
                                  // zero[23:22]
  // Entry count register write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data    // entries_in_use
);

  localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  cmd_t                cmd;
  logic [ADDR_W-1:0]   rd_addr;
  logic [IDX_W-1:0]    nearest_index;
  logic [DIST_W-1:0]   nearest_distance_sq;

  // Controller.
  npcs_ctrl #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_opcode  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd),
    .rd_addr    (rd_addr)
  );

  // Datapath.
  npcs_dpath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .rd_addr             (rd_addr),
    .entry_index         (in_tdata[3:0]),
    .red                 (in_tdata[11:4]),
    .green               (in_tdata[19:12]),
    .blue                (in_tdata[27:20]),
    .nearest_index       (nearest_index),
    .nearest_distance_sq (nearest_distance_sq)
  );

  assign out_tdata = {2'b00, nearest_distance_sq, nearest_index};

`ifndef ASSERT_OFF
  // A query keeps the input closed in the cycle after it is taken.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_QUERY)) |=> !in_tready)
    else $error("input reopened right after a query was taken");

  // The palette is never written while a scan reads it.
  a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.rd_en))
    else $error("palette written during a scan");

  // The greatest distance only appears when no entry was searched.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[21:4] == DIST_MAX)) |-> (out_tdata[3:0] == '0))
    else $error("empty search result carries a non-zero index");
`endif

endmodule

>>> sv/npcs_ctrl.sv
// ----------------------------------------------------------------------------
// npcs_ctrl: controller of the nearest palette colour search
// Holds the entry count register, steps the scan address over the palette,
// drains the datapath pipeline and owns the output valid flag.
// ----------------------------------------------------------------------------
module npcs_ctrl import npcs_pkg::*; #(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  input  logic                                   in_opcode,
  output logic                                   in_tready,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_valid,
  input  logic [CFG_W-1:0]                       cfg_data,
  output logic                                   cfg_ready,
  output cmd_t                                   cmd,
  output logic [((PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1)-1:0] rd_addr
);

  localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [ADDR_W-1:0]   last_r, last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0]    cfg_entries_r;
  logic [CNT_W-1:0]    eff_cnt;

  // The register is always ready to take a word.
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign rd_addr    = addr_r;

  // Entry count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entries_r <= CFG_RESET;
    end else if (cfg_valid) begin
      cfg_entries_r <= cfg_data;
    end
  end

  // Number of entries actually searched, clamped to the palette depth.
  always_comb begin
    if (32'(cfg_entries_r) > PALETTE_DEPTH) begin
      eff_cnt = CNT_W'(PALETTE_DEPTH);
    end else begin
      eff_cnt = CNT_W'(cfg_entries_r);
    end
  end

  // State, scan address and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    last_nxt  = last_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_opcode == OP_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.start = 1'b1;
            addr_nxt  = '0;
            last_nxt  = ADDR_W'(eff_cnt - 1'b1);
            if (eff_cnt == '0) begin
              state_nxt = ST_FIN;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (addr_r == last_r) begin
          state_nxt = ST_DRAIN_A;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_DRAIN_A: begin
        state_nxt = ST_DRAIN_B;
      end
      ST_DRAIN_B: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The output word stays until it is taken, unless a new one replaces it.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

>>> sv/npcs_dpath.sv
// ----------------------------------------------------------------------------
// npcs_dpath: datapath of the nearest palette colour search
// Palette memory, squared distance stage, best match compare and the output
// register.
// ----------------------------------------------------------------------------
module npcs_dpath import npcs_pkg::*; #(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cmd_t                                   cmd,
  input  logic [((PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1)-1:0] rd_addr,
  input  logic [IDX_W-1:0]                       entry_index,
  input  logic [COMP_W-1:0]                      red,
  input  logic [COMP_W-1:0]                      green,
  input  logic [COMP_W-1:0]                      blue,
  output logic [IDX_W-1:0]                       nearest_index,
  output logic [DIST_W-1:0]                      nearest_distance_sq
);

  localparam int ADDR_W  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int ENTRY_W = 3 * COMP_W;
  localparam int SQ_W    = 2 * COMP_W;

  logic [ENTRY_W-1:0] mem [PALETTE_DEPTH];
  logic [ENTRY_W-1:0] rdata_r;
  logic [ENTRY_W-1:0] pix_r;
  logic               s1_vld_r;
  logic [ADDR_W-1:0]  s1_idx_r;
  logic               s2_vld_r;
  logic [ADDR_W-1:0]  s2_idx_r;
  logic [DIST_W-1:0]  s2_dist_r;
  logic [ADDR_W-1:0]  best_idx_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               wr_ok;
  logic [COMP_W-1:0]  dr, dg, db;
  logic [SQ_W-1:0]    sqr, sqg, sqb;
  logic [DIST_W-1:0]  dist_sum;

  function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // Writes to slots beyond the palette are dropped.
  assign wr_ok = cmd.wr_en && (32'(entry_index) < PALETTE_DEPTH);

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[ADDR_W'(entry_index)] <= {red, green, blue};
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Query pixel, latched when the query is taken.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pix_r <= {red, green, blue};
    end
  end

  // Squared distance between the read entry and the pixel.
  always_comb begin
    dr       = abs_diff(rdata_r[3*COMP_W-1:2*COMP_W], pix_r[3*COMP_W-1:2*COMP_W]);
    dg       = abs_diff(rdata_r[2*COMP_W-1:COMP_W],   pix_r[2*COMP_W-1:COMP_W]);
    db       = abs_diff(rdata_r[COMP_W-1:0],          pix_r[COMP_W-1:0]);
    sqr      = SQ_W'(dr) * SQ_W'(dr);
    sqg      = SQ_W'(dg) * SQ_W'(dg);
    sqb      = SQ_W'(db) * SQ_W'(db);
    dist_sum = DIST_W'(sqr) + DIST_W'(sqg) + DIST_W'(sqb);
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.rd_en;
      s2_vld_r <= s1_vld_r;
    end
  end

  // Pipeline payload: entry index follows its read data, then its distance.
  always_ff @(posedge clk) begin
    s1_idx_r  <= rd_addr;
    s2_idx_r  <= s1_idx_r;
    s2_dist_r <= dist_sum;
  end

  // Best match so far; a strictly smaller distance is needed to replace it,
  // so the lowest index wins a tie. Every real distance beats the start value.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_idx_r  <= '0;
      best_dist_r <= DIST_MAX;
    end else if (s2_vld_r && (s2_dist_r < best_dist_r)) begin
      best_idx_r  <= s2_idx_r;
      best_dist_r <= s2_dist_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_idx_r  <= IDX_W'(best_idx_r);
      out_dist_r <= best_dist_r;
    end
  end

  assign nearest_index       = out_idx_r;
  assign nearest_distance_sq = out_dist_r;

endmodule
